// ===== design/sfc_pkg.sv =====
// shared types and constants for the sphere frustum cull block
package sfc_pkg;

	localparam int NumPlanesMax = 6;
	localparam int NumPlanesDef = 6;
	localparam int CoordW       = 16;
	localparam int RadW         = 15;
	localparam int MaskW        = 6;
	localparam int HintW        = 3;
	localparam int CfgIdxW      = 3;
	localparam int CfgW         = 64;
	localparam int CoefW        = 16;
	localparam int ProdW        = 2 * CoordW;
	localparam int FracW        = 14;
	localparam int AccW         = ProdW + 2;

	typedef enum logic [1:0] {
		CULL_INSIDE  = 2'd0,
		CULL_PARTIAL = 2'd1,
		CULL_OUTSIDE = 2'd2
	} verdict_t;

	typedef struct packed {
		logic outside;
		logic straddle;
	} plane_cls_t;

	typedef struct packed {
		logic [MaskW-1:0] outside;
		logic [MaskW-1:0] straddle;
	} cls_vec_t;

endpackage

// ===== design/sfc_if.sv =====
// item channels: sphere in, classification out
interface sfc_in_if;
	logic                            valid;
	logic                            ready;
	logic signed [sfc_pkg::CoordW-1:0] center_x;
	logic signed [sfc_pkg::CoordW-1:0] center_y;
	logic signed [sfc_pkg::CoordW-1:0] center_z;
	logic [sfc_pkg::RadW-1:0]        radius;
	logic [sfc_pkg::MaskW-1:0]       plane_mask;
	logic [sfc_pkg::HintW-1:0]       hint_plane;

	modport source (output valid, center_x, center_y, center_z, radius, plane_mask,
		hint_plane, input ready);
	modport sink (input valid, center_x, center_y, center_z, radius, plane_mask,
		hint_plane, output ready);
endinterface

interface sfc_out_if;
	logic                      valid;
	logic                      ready;
	sfc_pkg::verdict_t         verdict;
	logic [sfc_pkg::MaskW-1:0] partial_mask;
	logic [sfc_pkg::HintW-1:0] next_hint;

	modport source (output valid, verdict, partial_mask, next_hint, input ready);
	modport sink (input valid, verdict, partial_mask, next_hint, output ready);
endinterface

// ===== design/sphere_frustum_cull_masked.sv =====
// top level: plane registers, three-stage sphere versus frustum pipeline
//
// sphere (sink) takes one sphere per item: centre, radius, the mask of planes
// still to test and the hint plane. result (source) gives one item per sphere:
// inside, partial or outside, the straddled planes (or the input mask when
// outside) and the updated hint. Items leave in the order they arrived.
// The plane coefficients are written through cfg_we / cfg_index / cfg_wdata,
// one 64-bit register per plane. The user must write them only while no
// sphere is in flight; the block itself does not enforce this.
// Three register stages, the result item driven from stage three. Stage one
// holds the three products of every plane, stage two adds them with the plane
// offset and compares against the radius, stage three holds the resolved mask
// and hint. All planes run in parallel, so one sphere is taken every cycle
// while result takes its items.
// When result is not taken the stages fill up and sphere.ready falls once
// every stage holds an item; nothing is dropped or repeated.
// Reset clears the pipeline valid bits and sets every plane register to zero.
module sphere_frustum_cull_masked #(
	parameter int NUM_PLANES = sfc_pkg::NumPlanesDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sfc_in_if.sink                       sphere,
	sfc_out_if.source                    result,
	input  logic                         cfg_we,
	input  logic [sfc_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [sfc_pkg::CfgW-1:0]     cfg_wdata
);
	import sfc_pkg::*;

	logic [CfgW-1:0]  plane_q [NUM_PLANES];
	logic             v_s1, v_s2, v_s3;
	logic             adv1, adv2, adv3;
	logic [RadW-1:0]  radius_s1;
	logic [MaskW-1:0] mask_s1, mask_s2;
	logic [HintW-1:0] hint_s1, hint_s2;
	plane_cls_t       cls_s2 [NUM_PLANES];
	cls_vec_t         cls_vec;
	verdict_t         state_d, state_s3;
	logic [MaskW-1:0] pmask_d, pmask_s3;
	logic [HintW-1:0] hint_d, hint_s3;

	// plane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				plane_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_PLANES; i++) begin
				if (cfg_index == CfgIdxW'(i)) begin
					plane_q[i] <= cfg_wdata;
				end
			end
		end
	end

	// stall control
	assign adv3 = !v_s3 || result.ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign sphere.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= sphere.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			radius_s1 <= sphere.radius;
			mask_s1   <= sphere.plane_mask;
			hint_s1   <= sphere.hint_plane;
		end
		if (adv2) begin
			mask_s2 <= mask_s1;
			hint_s2 <= hint_s1;
		end
	end

	for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
		sfc_plane_eval u_eval (
			.clk       (clk),
			.en_s1     (adv1),
			.en_s2     (adv2),
			.coeffs    (plane_q[p]),
			.center_x  (sphere.center_x),
			.center_y  (sphere.center_y),
			.center_z  (sphere.center_z),
			.radius_s1 (radius_s1),
			.cls_s2    (cls_s2[p])
		);
	end

	always_comb begin
		cls_vec = '0;
		for (int i = 0; i < NUM_PLANES; i++) begin
			cls_vec.outside[i]  = cls_s2[i].outside;
			cls_vec.straddle[i] = cls_s2[i].straddle;
		end
	end

	sfc_resolve #(
		.NUM_PLANES (NUM_PLANES)
	) u_resolve (
		.cls          (cls_vec),
		.plane_mask   (mask_s2),
		.hint_plane   (hint_s2),
		.verdict      (state_d),
		.partial_mask (pmask_d),
		.next_hint    (hint_d)
	);

	always_ff @(posedge clk) begin
		if (adv3) begin
			state_s3 <= state_d;
			pmask_s3 <= pmask_d;
			hint_s3  <= hint_d;
		end
	end

	assign result.valid        = v_s3;
	assign result.verdict      = state_s3;
	assign result.partial_mask = pmask_s3;
	assign result.next_hint    = hint_s3;

	a_inside_empty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && state_s3 == CULL_INSIDE |-> pmask_s3 == '0)
		else $error("inside result with straddled planes");

	a_partial_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && state_s3 == CULL_PARTIAL |-> pmask_s3 != '0)
		else $error("partial result without straddled planes");

	a_reject_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && state_s3 == CULL_OUTSIDE && hint_s3 >= HintW'(NUM_PLANES)
		|-> 1'b0)
		else $error("outside result names a plane that does not exist");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && v_s3 && !result.ready |=> v_s2 && $stable(mask_s2) && $stable(hint_s2))
		else $error("second stage item lost under stall");

endmodule

// ===== design/sfc_plane_eval.sv =====
// one plane: products in the first stage, sum and radius compare in the second
module sfc_plane_eval (
	input  logic                              clk,
	input  logic                              en_s1,
	input  logic                              en_s2,
	input  logic [sfc_pkg::CfgW-1:0]          coeffs,
	input  logic signed [sfc_pkg::CoordW-1:0] center_x,
	input  logic signed [sfc_pkg::CoordW-1:0] center_y,
	input  logic signed [sfc_pkg::CoordW-1:0] center_z,
	input  logic [sfc_pkg::RadW-1:0]          radius_s1,
	output sfc_pkg::plane_cls_t               cls_s2
);
	import sfc_pkg::*;

	logic signed [CoefW-1:0] coef_a, coef_b, coef_c;
	logic signed [ProdW-1:0] prod_a_s1, prod_b_s1, prod_c_s1;
	logic [CoefW-1:0]        d_s1;
	logic signed [AccW-1:0]  sdist;
	logic signed [AccW-1:0]  rad;
	plane_cls_t              cls;

	assign coef_a = coeffs[CoefW-1:0];
	assign coef_b = coeffs[2*CoefW-1:CoefW];
	assign coef_c = coeffs[3*CoefW-1:2*CoefW];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			prod_a_s1 <= coef_a * center_x;
			prod_b_s1 <= coef_b * center_y;
			prod_c_s1 <= coef_c * center_z;
			d_s1      <= coeffs[4*CoefW-1:3*CoefW];
		end
	end

	always_comb begin
		sdist = {{(AccW-ProdW){prod_a_s1[ProdW-1]}}, prod_a_s1}
			+ {{(AccW-ProdW){prod_b_s1[ProdW-1]}}, prod_b_s1}
			+ {{(AccW-ProdW){prod_c_s1[ProdW-1]}}, prod_c_s1}
			+ {{(AccW-CoefW-FracW){d_s1[CoefW-1]}}, d_s1, {FracW{1'b0}}};
		rad = {{(AccW-RadW-FracW){1'b0}}, radius_s1, {FracW{1'b0}}};
		cls.outside  = sdist < -rad;
		cls.straddle = !cls.outside && (sdist < rad);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			cls_s2 <= cls;
		end
	end

endmodule

// ===== design/sfc_resolve.sv =====
// combines the per-plane classes with mask and hint into one result
module sfc_resolve #(
	parameter int NUM_PLANES = sfc_pkg::NumPlanesDef
) (
	input  sfc_pkg::cls_vec_t          cls,
	input  logic [sfc_pkg::MaskW-1:0]  plane_mask,
	input  logic [sfc_pkg::HintW-1:0]  hint_plane,
	output sfc_pkg::verdict_t          verdict,
	output logic [sfc_pkg::MaskW-1:0]  partial_mask,
	output logic [sfc_pkg::HintW-1:0]  next_hint
);
	import sfc_pkg::*;

	logic [MaskW-1:0] tested;
	logic [MaskW-1:0] rej;
	logic [MaskW-1:0] strad;
	logic             hint_rej;
	logic             any_rej;
	logic [HintW-1:0] first_rej;

	always_comb begin
		for (int i = 0; i < MaskW; i++) begin
			tested[i] = plane_mask[i] && (i < NUM_PLANES);
		end
		rej   = cls.outside & tested;
		strad = cls.straddle & tested;
		hint_rej  = 1'b0;
		first_rej = '0;
		for (int i = MaskW - 1; i >= 0; i--) begin
			if (rej[i]) begin
				first_rej = HintW'(i);
			end
			if (rej[i] && hint_plane == HintW'(i)) begin
				hint_rej = 1'b1;
			end
		end
		any_rej = |rej;

		if (any_rej) begin
			verdict      = CULL_OUTSIDE;
			partial_mask = plane_mask;
			next_hint    = hint_rej ? hint_plane : first_rej;
		end else begin
			verdict      = (|strad) ? CULL_PARTIAL : CULL_INSIDE;
			partial_mask = strad;
			next_hint    = hint_plane;
		end
	end

endmodule

// ===== sim/sfc_cull_check.sv =====
// checker: predicts the result of every accepted sphere and compares it on the result channel
`timescale 1ns / 100ps
module sfc_cull_check (
	input  logic                        clk,
	input  logic                        arst_n,
	sfc_in_if                           sphere,
	sfc_out_if                          result,
	input  logic                        cfg_we,
	input  logic [sfc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [sfc_pkg::CfgW-1:0]    cfg_wdata,
	output int                          errors,
	output int                          pending
);
	import sfc_pkg::*;

	localparam int NumPlanes = NumPlanesDef;
	localparam int Unit      = 1 << FracW;

	typedef struct packed {
		verdict_t         state;
		logic [MaskW-1:0] mask;
		logic [HintW-1:0] hint;
	} cull_res_t;

	logic [CfgW-1:0] planes [NumPlanes];
	cull_res_t       expected_cull [$];
	cull_res_t       want;
	int              mismatches;

	function automatic plane_cls_t plane_side(input int idx, input logic signed [CoordW-1:0] cx,
		input logic signed [CoordW-1:0] cy, input logic signed [CoordW-1:0] cz,
		input logic [RadW-1:0] rad);
		logic signed [CoefW-1:0] a, b, c, d;
		logic signed [AccW+1:0]  sdist, lim;
		plane_cls_t              cls;
		a = planes[idx][15:0];
		b = planes[idx][31:16];
		c = planes[idx][47:32];
		d = planes[idx][63:48];
		sdist = a * cx + b * cy + c * cz + d * Unit;
		lim = rad;
		lim = lim <<< FracW;
		cls.outside = sdist < -lim;
		cls.straddle = !cls.outside && (sdist < lim);
		return cls;
	endfunction

	function automatic cull_res_t classify_sphere(input logic signed [CoordW-1:0] cx,
		input logic signed [CoordW-1:0] cy, input logic signed [CoordW-1:0] cz,
		input logic [RadW-1:0] rad, input logic [MaskW-1:0] mask, input logic [HintW-1:0] hint);
		cull_res_t        res;
		plane_cls_t       cls;
		logic [MaskW-1:0] straddled;
		straddled = '0;
		res.state = CULL_OUTSIDE;
		res.mask = mask;
		res.hint = hint;
		if (hint < NumPlanes && mask[hint]) begin
			cls = plane_side(int'(hint), cx, cy, cz, rad);
			if (cls.outside)
				return res;
			if (cls.straddle)
				straddled[hint] = 1'b1;
		end
		for (int p = 0; p < NumPlanes; p++) begin
			if (p == hint || !mask[p])
				continue;
			cls = plane_side(p, cx, cy, cz, rad);
			if (cls.outside) begin
				res.hint = HintW'(p);
				return res;
			end
			if (cls.straddle)
				straddled[p] = 1'b1;
		end
		if (straddled != '0)
			res.state = CULL_PARTIAL;
		else
			res.state = CULL_INSIDE;
		res.mask = straddled;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NumPlanes; p++)
				planes[p] = '0;
			expected_cull.delete();
			mismatches = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we && cfg_index < NumPlanes)
				planes[cfg_index] = cfg_wdata;
			if (sphere.valid && sphere.ready)
				expected_cull.push_back(classify_sphere(sphere.center_x, sphere.center_y,
					sphere.center_z, sphere.radius, sphere.plane_mask, sphere.hint_plane));
			if (result.valid && result.ready) begin
				if (expected_cull.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result item: state %0d mask %h hint %0d",
							result.verdict, result.partial_mask, result.next_hint);
					mismatches++;
				end else begin
					want = expected_cull.pop_front();
					if (want.state !== result.verdict || want.mask !== result.partial_mask ||
						want.hint !== result.next_hint) begin
						if (mismatches < 10)
							$display({"cull mismatch: expected state %0d mask %h hint %0d, ",
								"got state %0d mask %h hint %0d"},
								want.state, want.mask, want.hint,
								result.verdict, result.partial_mask, result.next_hint);
						mismatches++;
					end
				end
			end
			errors <= mismatches;
			pending <= expected_cull.size();
		end
	end

endmodule

// ===== sim/tb.sv =====
// testbench top: clock, reset, plane set-up, sphere stimulus, result back-pressure and verdict
`timescale 1ns / 100ps
module tb;
	import sfc_pkg::*;

	localparam int NumPlanes  = NumPlanesDef;
	localparam int StallLimit = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgW-1:0]    cfg_wdata;
	int                 cull_errors;
	int                 cull_pending;
	int                 burst_left;

	sfc_in_if  sphere ();
	sfc_out_if result ();

	sphere_frustum_cull_masked dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sphere    (sphere),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	sfc_cull_check chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.sphere    (sphere),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (cull_errors),
		.pending   (cull_pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic offer_sphere(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
		input logic [CoordW-1:0] z, input logic [RadW-1:0] r, input logic [MaskW-1:0] m,
		input logic [HintW-1:0] h);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				sphere.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		sphere.center_x = x;
		sphere.center_y = y;
		sphere.center_z = z;
		sphere.radius = r;
		sphere.plane_mask = m;
		sphere.hint_plane = h;
		sphere.valid = 1'b1;
		@(posedge clk);
		while (!sphere.ready)
			@(posedge clk);
		burst_left--;
	endtask

	task automatic settle();
		@(negedge clk);
		sphere.valid = 1'b0;
		while (cull_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_plane(input int idx, input logic [CfgW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CfgIdxW'(idx);
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// axis-aligned box of the given half size, normals optionally tilted
	task automatic set_box(input int half, input int tilt);
		int coef [3];
		for (int p = 0; p < NumPlanes; p++) begin
			for (int k = 0; k < 3; k++)
				coef[k] = (tilt == 0) ? 0 : int'($urandom_range(0, 2 * tilt)) - tilt;
			coef[p / 2] = (p % 2 == 0) ? 16384 : -16384;
			write_plane(p, {16'(half), 16'(coef[2]), 16'(coef[1]), 16'(coef[0])});
		end
	endtask

	function automatic logic [CoordW-1:0] near_coord(input int span);
		int v;
		v = $urandom_range(0, 2 * span);
		v = v - span;
		return v[CoordW-1:0];
	endfunction

	function automatic logic [CoordW-1:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'hffff;
		endcase
	endfunction

	task automatic random_sphere(input int half);
		int               k, span;
		logic [31:0]      w0, w1, w2;
		logic [CoordW-1:0] x, y, z;
		logic [RadW-1:0]  r;
		logic [MaskW-1:0] m;
		logic [HintW-1:0] h;
		k = $urandom_range(0, 15);
		span = half + 2000;
		if (span > 32767)
			span = 32767;
		w0 = $urandom();
		w1 = $urandom();
		w2 = $urandom();
		x = near_coord(span);
		y = near_coord(span);
		z = near_coord(span);
		r = RadW'($urandom_range(0, 1500));
		m = $urandom_range(0, 1) ? 6'h3f : w2[5:0];
		h = HintW'($urandom_range(0, NumPlanes - 1));
		if (k >= 10 && k < 13) begin
			x = w0[15:0];
			y = w0[31:16];
			z = w1[15:0];
			r = w1[30:16];
			m = w2[5:0];
			h = w2[8:6];
		end else if (k == 13) begin
			x = extreme_coord();
			y = extreme_coord();
			z = extreme_coord();
			r = $urandom_range(0, 1) ? '1 : '0;
			m = w2[5:0];
			h = HintW'($urandom_range(0, 7));
		end else if (k > 13) begin
			m = w2[5:0];
			h = HintW'($urandom_range(NumPlanes, 7));
		end
		offer_sphere(x, y, z, r, m, h);
	endtask

	initial begin
		int cyc;
		int mode;
		cyc = 0;
		mode = 0;
		result.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (cyc % 97 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: result.ready = 1'b1;
				1: result.ready = $urandom_range(0, 1);
				2: result.ready = ($urandom_range(0, 3) == 0);
				default: result.ready = (cyc % 7) < 4;
			endcase
			cyc++;
		end
	end

	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < StallLimit) begin
			@(posedge clk);
			if ((sphere.valid && sphere.ready) || (result.valid && result.ready))
				idle = 0;
			else
				idle++;
		end
		$display("sphere_frustum_cull_masked regression: fail");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		sphere.valid = 1'b0;
		sphere.center_x = '0;
		sphere.center_y = '0;
		sphere.center_z = '0;
		sphere.radius = '0;
		sphere.plane_mask = '0;
		sphere.hint_plane = '0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// planes still at reset
		offer_sphere(0, 0, 0, 0, 63, 0);
		offer_sphere(-32768, 32767, -1, 32767, 63, 6);
		repeat (150) random_sphere(1000);
		settle();

		set_box(1000, 0);
		offer_sphere(0, 0, 0, 0, 63, 0);
		offer_sphere(0, 0, 0, 32767, 63, 0);
		offer_sphere(-32768, 0, 0, 0, 63, 0);
		offer_sphere(-32768, 0, 0, 0, 63, 3);
		offer_sphere(32767, 0, 0, 0, 63, 3);
		offer_sphere(0, -32768, 32767, 0, 63, 5);
		offer_sphere(-32768, 0, 0, 0, 62, 0);
		offer_sphere(-32768, 0, 0, 0, 63, 6);
		offer_sphere(0, 0, 0, 5, 63, 7);
		offer_sphere(0, 0, 0, 0, 0, 2);
		offer_sphere(-1500, 0, 0, 500, 63, 1);
		offer_sphere(-1501, 0, 0, 500, 63, 1);
		offer_sphere(500, 0, 0, 500, 63, 0);
		offer_sphere(501, 0, 0, 500, 63, 0);
		offer_sphere(900, 900, -900, 200, 63, 4);
		offer_sphere(900, 900, -900, 200, 21, 4);
		offer_sphere(32767, 32767, 32767, 32767, 63, 2);
		offer_sphere(-32768, -32768, -32768, 32767, 63, 1);
		offer_sphere(2000, 0, 0, 100, 42, 0);
		offer_sphere(0, 0, 2000, 0, 63, 7);
		repeat (350) random_sphere(1000);
		settle();

		write_plane(0, 64'h7fff_7fff_7fff_7fff);
		write_plane(1, 64'h8000_8000_8000_8000);
		write_plane(2, 64'h0000_0000_0000_0000);
		write_plane(3, 64'hffff_ffff_ffff_ffff);
		write_plane(4, 64'h8000_7fff_8000_7fff);
		write_plane(5, 64'h7fff_8000_7fff_8000);
		repeat (250) random_sphere(20000);
		settle();

		for (int p = 0; p < NumPlanes; p++)
			write_plane(p, {$urandom(), $urandom()});
		repeat (350) random_sphere(8000);
		settle();

		set_box(12000, 3000);
		repeat (175) random_sphere(12000);
		settle();
		repeat (175) random_sphere(12000);
		settle();

		set_box(200, 500);
		repeat (300) random_sphere(600);
		settle();

		repeat (8) @(posedge clk);
		if (cull_errors == 0 && cull_pending == 0)
			$display("sphere_frustum_cull_masked regression: pass");
		else
			$display("sphere_frustum_cull_masked regression: fail");
		$finish;
	end

endmodule
